### hw/rtl/hydrogen_bond_pair_detector_core_macros.svh
// Assertion macros for the hydrogen bond pair detector.
`ifndef HYDROGEN_BOND_PAIR_DETECTOR_CORE_MACROS_SVH
`define HYDROGEN_BOND_PAIR_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HBPD_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HBPD_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hbpd_pkg.sv
// Shared types, widths and helper functions for the hydrogen bond pair detector.
`default_nettype none

package hbpd_pkg;

    localparam int COORD_W      = 24;
    localparam int PIDX_W       = 12;
    localparam int DIST_W       = 24;
    localparam int ANG_W        = 16;
    localparam int OCC_W        = 24;
    localparam int SUM_W        = 48;
    localparam int FH_W         = 13;
    localparam int FRM_W        = 24;
    localparam int DCUT_W       = 40;
    localparam int COS_W        = 16;
    localparam int SQ_IN_W      = 64;
    localparam int SQ_OUT_W     = 32;
    localparam int CW           = 40;   // CORDIC x/y width
    localparam int ZW           = 24;   // CORDIC angle accumulator, pi/2^20 units
    localparam int CORDIC_STEPS = 19;

    localparam logic signed [COS_W-1:0] COS_CUT_RST = -16'sd23170;

    typedef struct packed {
        logic [OCC_W-1:0] occ;
        logic [SUM_W-1:0] dsum;
        logic [SUM_W-1:0] asum;
    } stat_t;

    // atan(2^-i) in pi/2^20 units
    function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:    r = 24'sd262144;
            5'd1:    r = 24'sd154753;
            5'd2:    r = 24'sd81767;
            5'd3:    r = 24'sd41506;
            5'd4:    r = 24'sd20834;
            5'd5:    r = 24'sd10427;
            5'd6:    r = 24'sd5215;
            5'd7:    r = 24'sd2608;
            5'd8:    r = 24'sd1304;
            5'd9:    r = 24'sd652;
            5'd10:   r = 24'sd326;
            5'd11:   r = 24'sd163;
            5'd12:   r = 24'sd81;
            5'd13:   r = 24'sd41;
            5'd14:   r = 24'sd20;
            5'd15:   r = 24'sd10;
            5'd16:   r = 24'sd5;
            5'd17:   r = 24'sd3;
            5'd18:   r = 24'sd1;
            default: r = 24'sd0;
        endcase
        return r;
    endfunction

    // arithmetic shift right, truncating toward zero
    function automatic logic signed [CW-1:0] tshr(input logic signed [CW-1:0] v,
                                                  input logic [4:0] s);
        logic [CW-1:0] mag;
        logic [CW-1:0] q;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        q   = mag >> s;
        return v[CW-1] ? -$signed(q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hbpd_ifs.sv
// Valid/ready channel interfaces for pair items and result items.
`default_nettype none

interface hbpd_pair_if import hbpd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] acc_x;
    logic signed [COORD_W-1:0] acc_y;
    logic signed [COORD_W-1:0] acc_z;
    logic signed [COORD_W-1:0] hyd_x;
    logic signed [COORD_W-1:0] hyd_y;
    logic signed [COORD_W-1:0] hyd_z;
    logic signed [COORD_W-1:0] don_x;
    logic signed [COORD_W-1:0] don_y;
    logic signed [COORD_W-1:0] don_z;
    logic [PIDX_W-1:0]         pair_index;
    logic                      same_atom;
    logic                      frame_end;

    modport source (output valid, acc_x, acc_y, acc_z, hyd_x, hyd_y, hyd_z,
                    don_x, don_y, don_z, pair_index, same_atom, frame_end,
                    input ready);
    modport sink   (input valid, acc_x, acc_y, acc_z, hyd_x, hyd_y, hyd_z,
                    don_x, don_y, don_z, pair_index, same_atom, frame_end,
                    output ready);
endinterface

interface hbpd_result_if import hbpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              is_hbond;
    logic [PIDX_W-1:0] pair_id;
    logic [DIST_W-1:0] distance;
    logic [ANG_W-1:0]  angle;
    logic [OCC_W-1:0]  pair_frames;
    logic [SUM_W-1:0]  pair_dist_sum;
    logic [SUM_W-1:0]  pair_angle_sum;
    logic [FH_W-1:0]   frame_hbonds;
    logic [FRM_W-1:0]  frames_seen;
    logic              last;

    modport source (output valid, is_hbond, pair_id, distance, angle, pair_frames,
                    pair_dist_sum, pair_angle_sum, frame_hbonds, frames_seen, last,
                    input ready);
    modport sink   (input valid, is_hbond, pair_id, distance, angle, pair_frames,
                    pair_dist_sum, pair_angle_sum, frame_hbonds, frames_seen, last,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/hbpd_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none

module hbpd_isqrt import hbpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_IN_W-1:0]  value,
    output logic                done,
    output logic [SQ_OUT_W-1:0] root
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          k_reg, k_next;
    logic [SQ_IN_W-1:0]  v_reg, v_next;
    logic [SQ_IN_W-1:0]  r_reg, r_next;
    logic [SQ_IN_W-1:0]  bit_val;
    logic [SQ_IN_W-1:0]  trial;

    always_comb
    begin
        bit_val   = SQ_IN_W'(1) << {k_reg, 1'b0};
        trial     = r_reg + bit_val;
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = 5'd31;
            v_next    = value;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_val;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            k_next = k_reg - 5'd1;
            if (k_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign root = r_reg[SQ_OUT_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/hydrogen_bond_pair_detector_core.sv
// Hydrogen bond pair detector: geometric test, per-pair statistics table, frame counts.
// Each pair beat carries an acceptor, a donor hydrogen and a donor heavy atom. The block
// checks the squared A-D distance against dist_cut_sq, then the A-H-D angle through its
// cosine against cos_angle_cut, and on a hit updates the pair's occupancy count, distance
// sum and angle sum (all saturating) plus the per-frame hit count. Exactly one result
// beat is produced per pair beat. Work is done one pair at a time on a single shared
// 34x34 multiplier, a bit-serial square root and a shift-add CORDIC. A skipped pair
// goes straight to the table update, a pair that fails the distance test stops after
// the distance products, one that fails the angle test after the first root, and a hit
// takes longest; the root unit dominates (three roots on a hit). pair.ready is high
// only between pairs. After reset the statistics memory is cleared one entry per cycle,
// all MAX_PAIRS entries (at most 4096), before the first pair is taken; configuration
// writes are taken at any time. Registers sit at byte 0 (dist_cut_sq, 40 bits) and
// byte 8 (cos_angle_cut, Q1.15) of the APB port.
`default_nettype none
`include "hydrogen_bond_pair_detector_core_macros.svh"

module hydrogen_bond_pair_detector_core import hbpd_pkg::*;
#(
    parameter int MAX_PAIRS       = 4096,
    parameter int COORD_FRAC_BITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    hbpd_pair_if.sink   pair,
    hbpd_result_if.source result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // table depth: pair_index never addresses past 4096
    localparam int DEPTH = (MAX_PAIRS < (1 << PIDX_W)) ? MAX_PAIRS : (1 << PIDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam longint unsigned THREE_A = 64'd3 << COORD_FRAC_BITS;
    localparam logic [DCUT_W-1:0] DCUT_RST = DCUT_W'(THREE_A * THREE_A);
    localparam int DW  = COORD_W + 1;  // coordinate difference
    localparam int NW  = 16;           // scaled vector component
    localparam int MW  = 34;           // multiplier operand
    localparam int PW  = 2 * MW;       // product
    localparam int D2W = 50;

    localparam logic REG_DIST_CUT = 1'b0;
    localparam logic REG_COS_CUT  = 1'b1;

    typedef enum logic [7:0] {
        S_CLR    = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_SCALE  = 8'b0000_1000,
        S_SQRT   = 8'b0001_0000,
        S_CORDIC = 8'b0010_0000,
        S_RD     = 8'b0100_0000,
        S_UPD    = 8'b1000_0000
    } state_t;

    // multiplier micro-ops, run in order
    typedef enum logic [4:0] {
        OP_D0, OP_D1, OP_D2,
        OP_P0, OP_P1, OP_P2,
        OP_A0, OP_A1, OP_A2,
        OP_B0, OP_B1, OP_B2,
        OP_M, OP_CUT,
        OP_X0, OP_X1, OP_X2, OP_X3, OP_X4, OP_X5,
        OP_C0, OP_C1, OP_C2
    } op_t;

    typedef enum logic [1:0] {SQ_M, SQ_C, SQ_D} sq_tgt_t;

    // control
    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic                ph_reg, ph_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [DCUT_W-1:0]   dcut_reg, dcut_next;
    logic signed [COS_W-1:0] cos_reg, cos_next;
    logic [FH_W-1:0]     fh_reg, fh_next;
    logic [FRM_W-1:0]    frames_reg, frames_next;
    logic                sq_start_reg, sq_start_next;
    sq_tgt_t             sq_tgt_reg, sq_tgt_next;

    // datapath
    logic signed [DW-1:0]  d_reg [3];
    logic signed [DW-1:0]  d_next [3];
    logic [DW-1:0]         mag_a_reg [3];
    logic [DW-1:0]         mag_a_next [3];
    logic [DW-1:0]         mag_b_reg [3];
    logic [DW-1:0]         mag_b_next [3];
    logic [2:0]            sa_reg, sa_next, sb_reg, sb_next;
    logic                  a_nz_reg, a_nz_next, b_nz_reg, b_nz_next;
    logic signed [NW-1:0]  na_reg [3];
    logic signed [NW-1:0]  na_next [3];
    logic signed [NW-1:0]  nb_reg [3];
    logic signed [NW-1:0]  nb_next [3];
    logic [PIDX_W-1:0]     pidx_reg, pidx_next;
    logic                  fend_reg, fend_next;
    logic                  hit_reg, hit_next;
    logic [D2W-1:0]        d2_reg, d2_next;
    logic signed [34:0]    dot_reg, dot_next;
    logic [31:0]           n1_reg, n1_next, n2_reg, n2_next;
    logic signed [32:0]    cr_reg [3];
    logic signed [32:0]    cr_next [3];
    logic [63:0]           csq_reg, csq_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic [SQ_OUT_W-1:0]   m_reg, m_next;
    logic [SQ_OUT_W-1:0]   cmag_reg, cmag_next;
    logic [DIST_W-1:0]     dist_reg, dist_next;
    logic [ANG_W-1:0]      ang_reg, ang_next;
    logic signed [CW-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]  z_reg, z_next;
    logic [4:0]            i_reg, i_next;
    logic [SQ_IN_W-1:0]    sq_val_reg, sq_val_next;
    stat_t                 mem_q_reg;

    // result register
    logic                  o_hit_reg, o_hit_next;
    logic [PIDX_W-1:0]     o_pid_reg, o_pid_next;
    logic [DIST_W-1:0]     o_dist_reg, o_dist_next;
    logic [ANG_W-1:0]      o_ang_reg, o_ang_next;
    stat_t                 o_stat_reg, o_stat_next;
    logic [FH_W-1:0]       o_fh_reg, o_fh_next;
    logic [FRM_W-1:0]      o_frm_reg, o_frm_next;
    logic                  o_last_reg, o_last_next;

    // statistics memory
    stat_t                 mem [DEPTH];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    stat_t                 mem_wdata;

    // shared units
    logic signed [MW-1:0]  opa, opb;
    logic                  sq_done;
    logic [SQ_OUT_W-1:0]   sq_root;

    // scratch
    logic signed [COORD_W-1:0] acc [3];
    logic signed [COORD_W-1:0] hyd [3];
    logic signed [COORD_W-1:0] don [3];
    logic signed [DW-1:0]  va, vb;
    logic [D2W-1:0]        d2_sum;
    logic signed [49:0]    cut_lhs, cut_rhs;
    logic                  a_big, b_big;
    logic signed [CW-1:0]  tx, ty;
    logic signed [ZW-1:0]  zc;
    logic [ZW:0]           zr;
    logic                  inrange;
    logic                  fire;
    logic [SUM_W:0]        dsum_w, asum_w;
    stat_t                 stat_new;
    logic [FH_W-1:0]       fh_new;
    logic                  cfg_wr;

    hbpd_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start_reg),
        .value (sq_val_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3])
            REG_DIST_CUT: prdata = 64'(dcut_reg);
            REG_COS_CUT:  prdata = 64'($unsigned(cos_reg));
            default:      prdata = '0;
        endcase
    end

    // ---------------- operand select for the shared multiplier ----------------
    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (op_reg)
            OP_D0:   begin opa = MW'(d_reg[0]);  opb = MW'(d_reg[0]);  end
            OP_D1:   begin opa = MW'(d_reg[1]);  opb = MW'(d_reg[1]);  end
            OP_D2:   begin opa = MW'(d_reg[2]);  opb = MW'(d_reg[2]);  end
            OP_P0:   begin opa = MW'(na_reg[0]); opb = MW'(nb_reg[0]); end
            OP_P1:   begin opa = MW'(na_reg[1]); opb = MW'(nb_reg[1]); end
            OP_P2:   begin opa = MW'(na_reg[2]); opb = MW'(nb_reg[2]); end
            OP_A0:   begin opa = MW'(na_reg[0]); opb = MW'(na_reg[0]); end
            OP_A1:   begin opa = MW'(na_reg[1]); opb = MW'(na_reg[1]); end
            OP_A2:   begin opa = MW'(na_reg[2]); opb = MW'(na_reg[2]); end
            OP_B0:   begin opa = MW'(nb_reg[0]); opb = MW'(nb_reg[0]); end
            OP_B1:   begin opa = MW'(nb_reg[1]); opb = MW'(nb_reg[1]); end
            OP_B2:   begin opa = MW'(nb_reg[2]); opb = MW'(nb_reg[2]); end
            OP_M:    begin opa = $signed({2'b00, n1_reg}); opb = $signed({2'b00, n2_reg}); end
            OP_CUT:  begin opa = MW'(cos_reg);   opb = $signed({2'b00, m_reg}); end
            OP_X0:   begin opa = MW'(na_reg[1]); opb = MW'(nb_reg[2]); end
            OP_X1:   begin opa = MW'(na_reg[2]); opb = MW'(nb_reg[1]); end
            OP_X2:   begin opa = MW'(na_reg[2]); opb = MW'(nb_reg[0]); end
            OP_X3:   begin opa = MW'(na_reg[0]); opb = MW'(nb_reg[2]); end
            OP_X4:   begin opa = MW'(na_reg[0]); opb = MW'(nb_reg[1]); end
            OP_X5:   begin opa = MW'(na_reg[1]); opb = MW'(nb_reg[0]); end
            OP_C0:   begin opa = MW'(cr_reg[0]); opb = MW'(cr_reg[0]); end
            OP_C1:   begin opa = MW'(cr_reg[1]); opb = MW'(cr_reg[1]); end
            OP_C2:   begin opa = MW'(cr_reg[2]); opb = MW'(cr_reg[2]); end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    // ---------------- sequencer and datapath ----------------
    always_comb
    begin
        // hold by default
        state_next     = state_reg;
        op_next        = op_reg;
        ph_next        = ph_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        dcut_next      = dcut_reg;
        cos_next       = cos_reg;
        fh_next        = fh_reg;
        frames_next    = frames_reg;
        sq_start_next  = 1'b0;
        sq_tgt_next    = sq_tgt_reg;
        d_next         = d_reg;
        mag_a_next     = mag_a_reg;
        mag_b_next     = mag_b_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        a_nz_next      = a_nz_reg;
        b_nz_next      = b_nz_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        pidx_next      = pidx_reg;
        fend_next      = fend_reg;
        hit_next       = hit_reg;
        d2_next        = d2_reg;
        dot_next       = dot_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        cr_next        = cr_reg;
        csq_next       = csq_reg;
        prod_next      = prod_reg;
        m_next         = m_reg;
        cmag_next      = cmag_reg;
        dist_next      = dist_reg;
        ang_next       = ang_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        i_next         = i_reg;
        sq_val_next    = sq_val_reg;
        o_hit_next     = o_hit_reg;
        o_pid_next     = o_pid_reg;
        o_dist_next    = o_dist_reg;
        o_ang_next     = o_ang_reg;
        o_stat_next    = o_stat_reg;
        o_fh_next      = o_fh_reg;
        o_frm_next     = o_frm_reg;
        o_last_next    = o_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = pidx_reg[AW-1:0];
        mem_wdata      = '0;

        acc[0] = pair.acc_x; acc[1] = pair.acc_y; acc[2] = pair.acc_z;
        hyd[0] = pair.hyd_x; hyd[1] = pair.hyd_y; hyd[2] = pair.hyd_z;
        don[0] = pair.don_x; don[1] = pair.don_y; don[2] = pair.don_z;
        va      = '0;
        vb      = '0;
        d2_sum  = d2_reg + prod_reg[D2W-1:0];
        cut_lhs = {dot_reg, 15'b0};
        cut_rhs = 50'(prod_reg[48:0]);
        cut_rhs = $signed({prod_reg[48], prod_reg[48:0]});
        a_big   = 1'b0;
        b_big   = 1'b0;
        tx      = tshr(x_reg, i_reg);
        ty      = tshr(y_reg, i_reg);
        zc      = z_reg[ZW-1] ? '0 : z_reg;
        zr      = ({1'b0, zc} + (ZW+1)'(16)) >> 5;
        inrange = 32'(pidx_reg) < MAX_PAIRS;
        fire    = !out_valid_reg || result.ready;
        dsum_w  = {1'b0, mem_q_reg.dsum} + (SUM_W+1)'(dist_reg);
        asum_w  = {1'b0, mem_q_reg.asum} + (SUM_W+1)'(ang_reg);
        stat_new.occ  = (mem_q_reg.occ == '1) ? mem_q_reg.occ : mem_q_reg.occ + 1'b1;
        stat_new.dsum = dsum_w[SUM_W] ? '1 : dsum_w[SUM_W-1:0];
        stat_new.asum = asum_w[SUM_W] ? '1 : asum_w[SUM_W-1:0];
        fh_new  = (hit_reg && fh_reg != '1) ? fh_reg + 1'b1 : fh_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr)
        begin
            unique case (paddr[3])
                REG_DIST_CUT: dcut_next = pwdata[DCUT_W-1:0];
                REG_COS_CUT:  cos_next  = $signed(pwdata[COS_W-1:0]);
                default:      dcut_next = dcut_reg;
            endcase
        end

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (pair.valid)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        va            = DW'(acc[k]) - DW'(hyd[k]);
                        vb            = DW'(don[k]) - DW'(hyd[k]);
                        d_next[k]     = DW'(acc[k]) - DW'(don[k]);
                        sa_next[k]    = va[DW-1];
                        sb_next[k]    = vb[DW-1];
                        mag_a_next[k] = va[DW-1] ? DW'(-va) : DW'(va);
                        mag_b_next[k] = vb[DW-1] ? DW'(-vb) : DW'(vb);
                        cr_next[k]    = '0;
                    end
                    a_nz_next = (mag_a_next[0] | mag_a_next[1] | mag_a_next[2]) != '0;
                    b_nz_next = (mag_b_next[0] | mag_b_next[1] | mag_b_next[2]) != '0;
                    pidx_next = pair.pair_index;
                    fend_next = pair.frame_end;
                    hit_next  = 1'b0;
                    dist_next = '0;
                    ang_next  = '0;
                    d2_next   = '0;
                    dot_next  = '0;
                    n1_next   = '0;
                    n2_next   = '0;
                    csq_next  = '0;
                    op_next   = OP_D0;
                    ph_next   = 1'b0;
                    state_next = pair.same_atom ? S_RD : S_MUL;
                end
            end

            S_MUL:
            begin
                if (!ph_reg)
                begin
                    prod_next = opa * opb;
                    ph_next   = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    op_next = op_t'(op_reg + 5'd1);
                    unique case (op_reg)
                        OP_D0, OP_D1:
                            d2_next = d2_sum;
                        OP_D2:
                        begin
                            d2_next = d2_sum;
                            if (d2_sum <= D2W'(dcut_reg) && a_nz_reg && b_nz_reg)
                            begin
                                state_next = S_SCALE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_P0, OP_P1, OP_P2:
                            dot_next = dot_reg + $signed(prod_reg[34:0]);
                        OP_A0, OP_A1, OP_A2:
                            n1_next = n1_reg + prod_reg[31:0];
                        OP_B0, OP_B1, OP_B2:
                            n2_next = n2_reg + prod_reg[31:0];
                        OP_M:
                        begin
                            sq_val_next   = prod_reg[SQ_IN_W-1:0];
                            sq_start_next = 1'b1;
                            sq_tgt_next   = SQ_M;
                            state_next    = S_SQRT;
                        end
                        OP_CUT:
                        begin
                            // dot*32768 <= cut*|a||b|
                            if (cut_lhs > cut_rhs)
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_X0: cr_next[0] = cr_reg[0] + $signed(prod_reg[32:0]);
                        OP_X1: cr_next[0] = cr_reg[0] - $signed(prod_reg[32:0]);
                        OP_X2: cr_next[1] = cr_reg[1] + $signed(prod_reg[32:0]);
                        OP_X3: cr_next[1] = cr_reg[1] - $signed(prod_reg[32:0]);
                        OP_X4: cr_next[2] = cr_reg[2] + $signed(prod_reg[32:0]);
                        OP_X5: cr_next[2] = cr_reg[2] - $signed(prod_reg[32:0]);
                        OP_C0, OP_C1:
                            csq_next = csq_reg + prod_reg[63:0];
                        OP_C2:
                        begin
                            sq_val_next   = csq_reg + prod_reg[63:0];
                            sq_start_next = 1'b1;
                            sq_tgt_next   = SQ_C;
                            state_next    = S_SQRT;
                        end
                        default: state_next = S_RD;
                    endcase
                end
            end

            S_SCALE:
            begin
                // one-bit shift per cycle until all components fit 15 bits
                a_big = (mag_a_reg[0][DW-1:15] | mag_a_reg[1][DW-1:15] |
                         mag_a_reg[2][DW-1:15]) != '0;
                b_big = (mag_b_reg[0][DW-1:15] | mag_b_reg[1][DW-1:15] |
                         mag_b_reg[2][DW-1:15]) != '0;
                for (int k = 0; k < 3; k++)
                begin
                    if (a_big) mag_a_next[k] = mag_a_reg[k] >> 1;
                    if (b_big) mag_b_next[k] = mag_b_reg[k] >> 1;
                    na_next[k] = sa_reg[k] ? -$signed(mag_a_reg[k][NW-1:0])
                                           : $signed(mag_a_reg[k][NW-1:0]);
                    nb_next[k] = sb_reg[k] ? -$signed(mag_b_reg[k][NW-1:0])
                                           : $signed(mag_b_reg[k][NW-1:0]);
                end
                if (!a_big && !b_big)
                begin
                    op_next    = OP_P0;
                    ph_next    = 1'b0;
                    state_next = S_MUL;
                end
            end

            S_SQRT:
            begin
                if (sq_done)
                begin
                    unique case (sq_tgt_reg)
                        SQ_M:
                        begin
                            m_next     = sq_root;
                            op_next    = OP_CUT;
                            ph_next    = 1'b0;
                            state_next = S_MUL;
                        end
                        SQ_C:
                        begin
                            cmag_next     = sq_root;
                            sq_val_next   = SQ_IN_W'(d2_reg);
                            sq_start_next = 1'b1;
                            sq_tgt_next   = SQ_D;
                        end
                        SQ_D:
                        begin
                            dist_next = (sq_root[SQ_OUT_W-1:DIST_W] != '0) ? '1
                                                                       : sq_root[DIST_W-1:0];
                            // negative dot product: pre-rotate by pi/2
                            if (dot_reg < 0)
                            begin
                                x_next = CW'({1'b0, cmag_reg});
                                y_next = -CW'(dot_reg);
                                z_next = ZW'(1 << 19);
                            end
                            else
                            begin
                                x_next = CW'(dot_reg);
                                y_next = CW'({1'b0, cmag_reg});
                                z_next = '0;
                            end
                            i_next     = '0;
                            state_next = S_CORDIC;
                        end
                        default: state_next = S_RD;
                    endcase
                end
            end

            S_CORDIC:
            begin
                if (y_reg == '0 || i_reg == 5'(CORDIC_STEPS))
                begin
                    hit_next   = 1'b1;
                    ang_next   = (zr > (ZW+1)'(32768)) ? 16'h8000 : zr[ANG_W-1:0];
                    state_next = S_RD;
                end
                else
                begin
                    if (y_reg > 0)
                    begin
                        x_next = x_reg + ty;
                        y_next = y_reg - tx;
                        z_next = z_reg + atan_val(i_reg);
                    end
                    else
                    begin
                        x_next = x_reg - ty;
                        y_next = y_reg + tx;
                        z_next = z_reg - atan_val(i_reg);
                    end
                    i_next = i_reg + 5'd1;
                end
            end

            S_RD:
            begin
                state_next = S_UPD;
            end

            S_UPD:
            begin
                if (fire)
                begin
                    if (hit_reg && inrange)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = stat_new;
                    end
                    out_valid_next = 1'b1;
                    o_hit_next     = hit_reg;
                    o_pid_next     = pidx_reg;
                    o_dist_next    = dist_reg;
                    o_ang_next     = ang_reg;
                    o_stat_next    = !inrange ? '0 : (hit_reg ? stat_new : mem_q_reg);
                    o_fh_next      = fh_new;
                    o_last_next    = fend_reg;
                    if (fend_reg)
                    begin
                        fh_next     = '0;
                        frames_next = (frames_reg == '1) ? frames_reg : frames_reg + 1'b1;
                    end
                    else
                    begin
                        fh_next = fh_new;
                    end
                    o_frm_next = fend_reg ? ((frames_reg == '1) ? frames_reg
                                                                : frames_reg + 1'b1)
                                          : frames_reg;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            op_reg        <= OP_D0;
            ph_reg        <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            dcut_reg      <= DCUT_RST;
            cos_reg       <= COS_CUT_RST;
            fh_reg        <= '0;
            frames_reg    <= '0;
            sq_start_reg  <= 1'b0;
            sq_tgt_reg    <= SQ_M;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ph_reg        <= ph_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            dcut_reg      <= dcut_next;
            cos_reg       <= cos_next;
            fh_reg        <= fh_next;
            frames_reg    <= frames_next;
            sq_start_reg  <= sq_start_next;
            sq_tgt_reg    <= sq_tgt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        a_nz_reg   <= a_nz_next;
        b_nz_reg   <= b_nz_next;
        na_reg     <= na_next;
        nb_reg     <= nb_next;
        pidx_reg   <= pidx_next;
        fend_reg   <= fend_next;
        hit_reg    <= hit_next;
        d2_reg     <= d2_next;
        dot_reg    <= dot_next;
        n1_reg     <= n1_next;
        n2_reg     <= n2_next;
        cr_reg     <= cr_next;
        csq_reg    <= csq_next;
        prod_reg   <= prod_next;
        m_reg      <= m_next;
        cmag_reg   <= cmag_next;
        dist_reg   <= dist_next;
        ang_reg    <= ang_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        i_reg      <= i_next;
        sq_val_reg <= sq_val_next;
        o_hit_reg  <= o_hit_next;
        o_pid_reg  <= o_pid_next;
        o_dist_reg <= o_dist_next;
        o_ang_reg  <= o_ang_next;
        o_stat_reg <= o_stat_next;
        o_fh_reg   <= o_fh_next;
        o_frm_reg  <= o_frm_next;
        o_last_reg <= o_last_next;
    end

    // statistics memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            mem_q_reg <= mem[pidx_reg[AW-1:0]];
        end
    end

    // ---------------- ports ----------------
    assign pair.ready            = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.is_hbond       = o_hit_reg;
    assign result.pair_id        = o_pid_reg;
    assign result.distance       = o_dist_reg;
    assign result.angle          = o_ang_reg;
    assign result.pair_frames    = o_stat_reg.occ;
    assign result.pair_dist_sum  = o_stat_reg.dsum;
    assign result.pair_angle_sum = o_stat_reg.asum;
    assign result.frame_hbonds   = o_fh_reg;
    assign result.frames_seen    = o_frm_reg;
    assign result.last           = o_last_reg;

    // ---------------- assertions ----------------
    `HBPD_NEXT(a_busy_after_beat, pair.valid && pair.ready, state_reg != S_IDLE, "idle after pair beat")
    `HBPD_IMPLIES(a_result_from_upd, $rose(out_valid_reg), $past(state_reg) == S_UPD, "result not from update")
    `HBPD_IMPLIES(a_miss_is_zero, result.valid && !result.is_hbond, result.distance == 24'd0 && result.angle == 16'd0, "miss carries geometry")
    `HBPD_IMPLIES(a_table_write, mem_we && state_reg != S_CLR, state_reg == S_UPD && hit_reg, "table write without hit")

endmodule

`default_nettype wire

### test/hydrogen_bond_pair_detector_core_test.sv
// Self-checking testbench for the hydrogen bond pair detector core.
`timescale 1ns / 100ps

module hydrogen_bond_pair_detector_core_test;
    import hbpd_pkg::*;

    // Register map: index times 8 gives the byte address (one register is 40 bits).
    localparam int REG_DIST_CUT_SQ = 0;
    localparam int REG_COS_ANGLE_CUT = 1;

    localparam longint unsigned MAX24 = 64'hFF_FFFF;
    localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned MAX13 = 64'h1FFF;
    localparam int TABLE_DEPTH = 4096;
    localparam int SETTLE_CYCLES = 300;

    // angle step table, pi/2^20 units
    localparam longint ATAN_STEP [19] = '{262144, 154753, 81767, 41506, 20834, 10427,
        5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [COORD_W-1:0] acc_x, acc_y, acc_z;
        logic signed [COORD_W-1:0] hyd_x, hyd_y, hyd_z;
        logic signed [COORD_W-1:0] don_x, don_y, don_z;
        logic [PIDX_W-1:0]         pair_index;
        logic                      same_atom;
        logic                      frame_end;
    } pair_t;

    typedef struct {
        logic              is_hbond;
        logic [PIDX_W-1:0] pair_id;
        logic [DIST_W-1:0] distance;
        logic [ANG_W-1:0]  angle;
        logic [OCC_W-1:0]  pair_frames;
        logic [SUM_W-1:0]  pair_dist_sum;
        logic [SUM_W-1:0]  pair_angle_sum;
        logic [FH_W-1:0]   frame_hbonds;
        logic [FRM_W-1:0]  frames_seen;
        logic              last;
    } bond_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    hbpd_pair_if   pair_ch ();
    hbpd_result_if result_ch ();

    hydrogen_bond_pair_detector_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pair    (pair_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Shadow of the block: configuration, statistics tables, frame counters.
    logic [DCUT_W-1:0]        dist_cut = 40'd9437184;
    logic signed [COS_W-1:0]  cos_cut  = COS_CUT_RST;
    longint unsigned occ_tab  [TABLE_DEPTH] = '{default: 0};
    longint unsigned dsum_tab [TABLE_DEPTH] = '{default: 0};
    longint unsigned asum_tab [TABLE_DEPTH] = '{default: 0};
    longint unsigned frame_hits = 0;
    longint unsigned frame_count = 0;

    bond_t bond_q [$];      // predicted result beats, oldest first
    int    error_count = 0;
    int    burst_left = 0;
    int    cycle_count = 0;

    initial
    begin
        pair_ch.valid = 1'b0;
        pair_ch.acc_x = '0; pair_ch.acc_y = '0; pair_ch.acc_z = '0;
        pair_ch.hyd_x = '0; pair_ch.hyd_y = '0; pair_ch.hyd_z = '0;
        pair_ch.don_x = '0; pair_ch.don_y = '0; pair_ch.don_z = '0;
        pair_ch.pair_index = '0;
        pair_ch.same_atom = 1'b0;
        pair_ch.frame_end = 1'b0;
        result_ch.ready = 1'b0;
    end

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // shift right, rounding toward zero
    function automatic longint trunc_shr(input longint v, input int s);
        return (v >= 0) ? (v >>> s) : -((-v) >>> s);
    endfunction

    // shrink a vector until every component fits in 15 bits, keeping signs
    function automatic void shrink15(input vec3_t v, output vec3_t n);
        longint unsigned mag [3];
        longint unsigned top;
        int s;
        top = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? -v[i] : v[i];
            if (mag[i] > top) top = mag[i];
        end
        while ((top >> s) >= 32768) s++;
        for (int i = 0; i < 3; i++)
            n[i] = (v[i] < 0) ? -longint'(mag[i] >> s) : longint'(mag[i] >> s);
    endfunction

    // Geometric test plus statistics update for one accepted pair beat.
    function automatic bond_t detect_bond(input pair_t p);
        vec3_t a, h, d, va, vb, na, nb;
        longint dot, c0, c1, c2, x, y, z, nx, ny, t, cut;
        longint unsigned d2, n1, n2, m, cm, bond_len, ang;
        bit hit;
        bond_t r;
        a = '{p.acc_x, p.acc_y, p.acc_z};
        h = '{p.hyd_x, p.hyd_y, p.hyd_z};
        d = '{p.don_x, p.don_y, p.don_z};
        hit = 0;
        bond_len = 0;
        ang = 0;
        if (!p.same_atom)
        begin
            d2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                t = a[i] - d[i];
                d2 = d2 + longint'(t * t);
                va[i] = a[i] - h[i];
                vb[i] = d[i] - h[i];
            end
            // H on top of A or D: no angle, no hit
            if (d2 <= dist_cut && (va[0] | va[1] | va[2]) != 0 &&
                (vb[0] | vb[1] | vb[2]) != 0)
            begin
                shrink15(va, na);
                shrink15(vb, nb);
                dot = na[0] * nb[0] + na[1] * nb[1] + na[2] * nb[2];
                n1 = na[0] * na[0] + na[1] * na[1] + na[2] * na[2];
                n2 = nb[0] * nb[0] + nb[1] * nb[1] + nb[2] * nb[2];
                m = isqrt(n1 * n2);
                cut = cos_cut;
                if (dot * 32768 <= cut * longint'(m))
                begin
                    hit = 1;
                    bond_len = isqrt(d2);
                    if (bond_len > MAX24) bond_len = MAX24;
                    c0 = na[1] * nb[2] - na[2] * nb[1];
                    c1 = na[2] * nb[0] - na[0] * nb[2];
                    c2 = na[0] * nb[1] - na[1] * nb[0];
                    cm = isqrt(longint'(c0 * c0) + longint'(c1 * c1) + longint'(c2 * c2));
                    x = dot;
                    y = cm;
                    z = 0;
                    // obtuse: start from a quarter turn
                    if (x < 0)
                    begin
                        t = x;
                        x = y;
                        y = -t;
                        z = 64'sd1 << 19;
                    end
                    for (int i = 0; i < 19 && y != 0; i++)
                    begin
                        if (y > 0)
                        begin
                            nx = x + trunc_shr(y, i);
                            ny = y - trunc_shr(x, i);
                            z = z + ATAN_STEP[i];
                        end
                        else
                        begin
                            nx = x - trunc_shr(y, i);
                            ny = y + trunc_shr(x, i);
                            z = z - ATAN_STEP[i];
                        end
                        x = nx;
                        y = ny;
                    end
                    if (z < 0) z = 0;
                    ang = (longint'(z) + 16) >> 5;
                    if (ang > 32768) ang = 32768;
                end
            end
        end

        if (hit)
        begin
            if (frame_hits < MAX13) frame_hits++;
            if (occ_tab[p.pair_index] < MAX24) occ_tab[p.pair_index]++;
            dsum_tab[p.pair_index] = (dsum_tab[p.pair_index] + bond_len > MAX48) ?
                                     MAX48 : dsum_tab[p.pair_index] + bond_len;
            asum_tab[p.pair_index] = (asum_tab[p.pair_index] + ang > MAX48) ?
                                     MAX48 : asum_tab[p.pair_index] + ang;
        end

        r.is_hbond       = hit;
        r.pair_id        = p.pair_index;
        r.distance       = bond_len;
        r.angle          = ang;
        r.pair_frames    = occ_tab[p.pair_index];
        r.pair_dist_sum  = dsum_tab[p.pair_index];
        r.pair_angle_sum = asum_tab[p.pair_index];
        r.frame_hbonds   = frame_hits;
        // frame close takes effect after the hit count is reported
        if (p.frame_end)
        begin
            if (frame_count < MAX24) frame_count++;
            frame_hits = 0;
        end
        r.frames_seen = frame_count;
        r.last        = p.frame_end;
        return r;
    endfunction

    // APB write: setup cycle, then access cycle; lands when pready is seen.
    task automatic write_reg(input int idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 8);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DIST_CUT_SQ)
            dist_cut = val[DCUT_W-1:0];
        else if (idx == REG_COS_ANGLE_CUT)
            cos_cut = val[COS_W-1:0];
    endtask

    // Offer one pair beat; bursts of back-to-back beats with random gaps between.
    task automatic send_pair(input pair_t p);
        if (burst_left == 0)
        begin
            pair_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        pair_ch.acc_x <= p.acc_x; pair_ch.acc_y <= p.acc_y; pair_ch.acc_z <= p.acc_z;
        pair_ch.hyd_x <= p.hyd_x; pair_ch.hyd_y <= p.hyd_y; pair_ch.hyd_z <= p.hyd_z;
        pair_ch.don_x <= p.don_x; pair_ch.don_y <= p.don_y; pair_ch.don_z <= p.don_z;
        pair_ch.pair_index <= p.pair_index;
        pair_ch.same_atom  <= p.same_atom;
        pair_ch.frame_end  <= p.frame_end;
        pair_ch.valid      <= 1'b1;
        do @(posedge clk); while (!pair_ch.ready);
        bond_q.insert(bond_q.size(), detect_bond(p));
        burst_left--;
    endtask

    // Wait out every outstanding result so the block is idle.
    task automatic drain();
        pair_ch.valid <= 1'b0;
        burst_left = 0;
        while (bond_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] rand_span(input int span);
        return COORD_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Plausible geometry: A near D, H somewhere around the A-D line.
    function automatic pair_t make_geometry(input int reach);
        pair_t p;
        int k;
        logic signed [COORD_W-1:0] ox, oy, oz;
        p.don_x = rand_span(8_000_000);
        p.don_y = rand_span(8_000_000);
        p.don_z = rand_span(8_000_000);
        ox = rand_span(reach);
        oy = rand_span(reach);
        oz = rand_span(reach);
        p.acc_x = p.don_x + ox;
        p.acc_y = p.don_y + oy;
        p.acc_z = p.don_z + oz;
        k = $urandom_range(16);
        p.hyd_x = p.don_x + ox * k / 16 + rand_span(400);
        p.hyd_y = p.don_y + oy * k / 16 + rand_span(400);
        p.hyd_z = p.don_z + oz * k / 16 + rand_span(400);
        p.pair_index = $urandom;
        p.same_atom  = ($urandom_range(15) == 0);
        p.frame_end  = ($urandom_range(15) == 0);
        return p;
    endfunction

    function automatic pair_t make_noise();
        pair_t p;
        p.acc_x = $urandom; p.acc_y = $urandom; p.acc_z = $urandom;
        p.hyd_x = $urandom; p.hyd_y = $urandom; p.hyd_z = $urandom;
        p.don_x = $urandom; p.don_y = $urandom; p.don_z = $urandom;
        p.pair_index = $urandom;
        p.same_atom  = $urandom;
        p.frame_end  = $urandom;
        return p;
    endfunction

    // Mostly realistic triples, a few tied to a small set of pairs to build up stats.
    task automatic run_random(input int count);
        pair_t p;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 80)
            begin
                p = make_geometry((sel < 20) ? 1500 : (sel < 60) ? 3000 : 6000);
                if (sel < 30) p.pair_index = $urandom_range(7);
            end
            else
                p = make_noise();
            send_pair(p);
        end
    endtask

    // Extremes of the fields, skipped pair, H on A, H on D, acute and obtuse angles.
    task automatic test_directed();
        pair_t p;
        p = make_geometry(2000);
        p.same_atom = 1'b0; p.frame_end = 1'b0; p.pair_index = 0;
        p.hyd_x = p.don_x - (p.acc_x - p.don_x) / 4;   // H a quarter of the way from D, x offset mirrored
        p.hyd_y = p.don_y + (p.acc_y - p.don_y) / 4;
        p.hyd_z = p.don_z + (p.acc_z - p.don_z) / 4;
        send_pair(p);
        p.same_atom = 1'b1;
        send_pair(p);
        p.same_atom = 1'b0;
        p.hyd_x = p.acc_x; p.hyd_y = p.acc_y; p.hyd_z = p.acc_z;   // H on A
        send_pair(p);
        p.hyd_x = p.don_x; p.hyd_y = p.don_y; p.hyd_z = p.don_z;   // H on D
        send_pair(p);
        p = '{default: 0};
        p.acc_x = 1500; p.hyd_x = 750; p.hyd_y = 900; p.pair_index = PIDX_W'(4095);
        send_pair(p);                                        // bent angle
        p.hyd_x = 750; p.hyd_y = 1; p.frame_end = 1'b1;
        send_pair(p);                                        // nearly straight
        p = '{default: 0};
        p.acc_x = 24'sh7FFFFF; p.acc_y = 24'sh7FFFFF; p.acc_z = 24'sh7FFFFF;
        p.don_x = -24'sh800000; p.don_y = -24'sh800000; p.don_z = -24'sh800000;
        p.pair_index = PIDX_W'(4095);
        send_pair(p);                                        // farthest apart
        p.hyd_x = 24'sh7FFFFF; p.hyd_y = -24'sh800000; p.hyd_z = 24'sh7FFFFF;
        p.don_x = 24'sh7FFFFF; p.don_y = 24'sh7FFFFF; p.don_z = -24'sh800000;
        p.frame_end = 1'b1;
        send_pair(p);
        for (int n = 0; n < 12; n++)
            send_pair(make_geometry(2500));
    endtask

    task automatic test_defaults();
        test_directed();
        run_random(400);
        drain();
    endtask

    // Largest distance cut and a cosine cut just below 1: nearly every pair hits; large sums.
    task automatic test_wide_open();
        write_reg(REG_DIST_CUT_SQ, 64'hFF_FFFF_FFFF);
        write_reg(REG_COS_ANGLE_CUT, 64'(16'sh7FFF));
        test_directed();
        run_random(400);
        drain();
    endtask

    // Only coincident atoms could pass distance; cosine at its lowest.
    task automatic test_closed();
        write_reg(REG_DIST_CUT_SQ, 64'd0);
        write_reg(REG_COS_ANGLE_CUT, 64'(16'sh8000));
        test_directed();
        run_random(200);
        drain();
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_DIST_CUT_SQ, 64'($urandom_range(50_000_000)));
            write_reg(REG_COS_ANGLE_CUT, 64'(COS_W'($urandom)));
            run_random(150);
            drain();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_wide_open();
        test_closed();
        test_random_settings();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("hydrogen_bond_pair_detector_core: match");
        else
            $display("hydrogen_bond_pair_detector_core: mismatch");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("hydrogen_bond_pair_detector_core: mismatch");
        $finish;
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result side: compare each accepted beat, then pick the next stall pattern.
    always @(posedge clk)
    begin
        bond_t e;
        cycle_count <= cycle_count + 1;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (bond_q.size() == 0)
            begin
                $error("result beat with nothing expected, pair_id %0d", result_ch.pair_id);
                error_count++;
            end
            else
            begin
                e = bond_q.pop_front();
                check_field("is_hbond", e.is_hbond, result_ch.is_hbond);
                check_field("pair_id", e.pair_id, result_ch.pair_id);
                check_field("distance", e.distance, result_ch.distance);
                check_field("angle", e.angle, result_ch.angle);
                check_field("pair_frames", e.pair_frames, result_ch.pair_frames);
                check_field("pair_dist_sum", e.pair_dist_sum, result_ch.pair_dist_sum);
                check_field("pair_angle_sum", e.pair_angle_sum, result_ch.pair_angle_sum);
                check_field("frame_hbonds", e.frame_hbonds, result_ch.frame_hbonds);
                check_field("frames_seen", e.frames_seen, result_ch.frames_seen);
                check_field("last", e.last, result_ch.last);
            end
        end
        // stall mode rotates with cycle_count[11:10]: open, coin flip, mostly stalled, mostly open
        case (cycle_count[11:10])
            2'd0:    result_ch.ready <= 1'b1;
            2'd1:    result_ch.ready <= $urandom_range(1);
            2'd2:    result_ch.ready <= ($urandom_range(7) == 0);
            default: result_ch.ready <= (cycle_count[2:0] != 3'd0);
        endcase
    end

endmodule
